[hw/rtl/rcfr_pkg.sv]
// ---------------------------------------------------------------------------
// rcfr_pkg: shared constants and types of the shape fill engine
// frame store geometry, opcodes, register indexes, command record
// ---------------------------------------------------------------------------
package rcfr_pkg;

    // frame store geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // opcodes
    localparam logic [1:0] OP_RECT   = 2'd0;
    localparam logic [1:0] OP_CIRCLE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // register indexes (byte address bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic        [6:0]    t_pix;    // canvas coordinate / canvas size
    typedef logic signed [9:0]    t_coord;  // signed working coordinate
    typedef logic        [AW-1:0] t_addr;
    typedef logic        [QPW-1:0] t_qptr;
    typedef logic        [QCW-1:0] t_qcnt;

    // classified command handed from front to back
    typedef struct packed {
        logic        is_read;
        logic        is_circle;
        logic        empty;       // nothing to draw, or read outside canvas
        t_pix        x_lo;
        t_pix        x_hi;
        t_pix        y_lo;
        t_pix        y_hi;
        t_addr       start_addr;  // address of (x_lo, y_lo)
        t_coord      cx;
        t_coord      cy;
        logic [15:0] r2;          // squared radius
        logic [23:0] colour;
    } t_cmd;

endpackage

[hw/rtl/rcfr_ram.sv]
// ---------------------------------------------------------------------------
// rcfr_ram: generic single write port, single read port ram
// read data registered, held while read enable is low
// ---------------------------------------------------------------------------
module rcfr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rcfr_front.sv]
// ---------------------------------------------------------------------------
// rcfr_front: request intake and classification
// clips the shape bounding box to the canvas and computes its start address
// ---------------------------------------------------------------------------
module rcfr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_block,
    input  logic [1:0]         i_opcode,
    input  logic signed [8:0]  i_center_x,
    input  logic signed [8:0]  i_center_y,
    input  logic [7:0]         i_size_a,
    input  logic [7:0]         i_size_b,
    input  logic [7:0]         i_fill_red,
    input  logic [7:0]         i_fill_green,
    input  logic [7:0]         i_fill_blue,
    input  rcfr_pkg::t_pix     i_width,
    input  rcfr_pkg::t_pix     i_height,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output rcfr_pkg::t_cmd     o_push_cmd
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_BOX  = 2'd1;
    localparam logic [1:0] F_ADDR = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [1:0]         r_op;
    logic signed [8:0]  r_cx;
    logic signed [8:0]  r_cy;
    logic [7:0]         r_sa;
    logic [7:0]         r_sb;
    logic [23:0]        r_colour;
    rcfr_pkg::t_cmd     r_cmd;

    rcfr_pkg::t_coord w_cx;
    rcfr_pkg::t_coord w_cy;
    rcfr_pkg::t_coord w_ext_x;
    rcfr_pkg::t_coord w_ext_y;
    rcfr_pkg::t_coord w_lo_x;
    rcfr_pkg::t_coord w_hi_x;
    rcfr_pkg::t_coord w_lo_y;
    rcfr_pkg::t_coord w_hi_y;
    rcfr_pkg::t_coord w_wm1;
    rcfr_pkg::t_coord w_hm1;
    rcfr_pkg::t_coord w_cl_lo_x;
    rcfr_pkg::t_coord w_cl_hi_x;
    rcfr_pkg::t_coord w_cl_lo_y;
    rcfr_pkg::t_coord w_cl_hi_y;
    logic              w_empty;
    logic [15:0]       w_r2;
    logic [13:0]       w_yw;
    logic              w_accept;

    assign o_ready      = (r_state == F_IDLE) && !i_block;
    assign w_accept     = i_valid && o_ready;
    assign o_push_valid = (r_state == F_PUSH);
    assign o_push_cmd   = r_cmd;

    // bounding box of the shape, then clipped to the canvas
    always_comb begin
        w_cx    = rcfr_pkg::t_coord'(r_cx);
        w_cy    = rcfr_pkg::t_coord'(r_cy);
        w_ext_x = '0;
        w_ext_y = '0;
        case (r_op)
            rcfr_pkg::OP_RECT: begin
                w_ext_x = rcfr_pkg::t_coord'({1'b0, r_sa[7:1]});
                w_ext_y = rcfr_pkg::t_coord'({1'b0, r_sb[7:1]});
            end
            rcfr_pkg::OP_CIRCLE: begin
                w_ext_x = rcfr_pkg::t_coord'({1'b0, r_sa});
                w_ext_y = rcfr_pkg::t_coord'({1'b0, r_sa});
            end
            default: begin
                w_ext_x = '0;
                w_ext_y = '0;
            end
        endcase
        w_lo_x = w_cx - w_ext_x;
        w_hi_x = w_cx + w_ext_x;
        w_lo_y = w_cy - w_ext_y;
        w_hi_y = w_cy + w_ext_y;
        w_wm1  = rcfr_pkg::t_coord'({1'b0, i_width}) - rcfr_pkg::t_coord'(1);
        w_hm1  = rcfr_pkg::t_coord'({1'b0, i_height}) - rcfr_pkg::t_coord'(1);
        w_cl_lo_x = w_lo_x[9] ? '0 : w_lo_x;
        w_cl_lo_y = w_lo_y[9] ? '0 : w_lo_y;
        w_cl_hi_x = (w_hi_x > w_wm1) ? w_wm1 : w_hi_x;
        w_cl_hi_y = (w_hi_y > w_hm1) ? w_hm1 : w_hi_y;
        w_empty   = (w_cl_lo_x > w_cl_hi_x) || (w_cl_lo_y > w_cl_hi_y) ||
                    ((r_op != rcfr_pkg::OP_RECT) && (r_op != rcfr_pkg::OP_CIRCLE) &&
                     (r_op != rcfr_pkg::OP_READ));
    end

    assign w_r2 = r_sa * r_sa;
    assign w_yw = r_cmd.y_lo * i_width;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_accept) n_state = F_BOX;
            end
            F_BOX:  n_state = F_ADDR;
            F_ADDR: n_state = F_PUSH;
            F_PUSH: begin
                if (i_push_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_opcode;
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_sa     <= i_size_a;
            r_sb     <= i_size_b;
            r_colour <= {i_fill_red, i_fill_green, i_fill_blue};
        end
        if (r_state == F_BOX) begin
            r_cmd.is_read    <= (r_op == rcfr_pkg::OP_READ);
            r_cmd.is_circle  <= (r_op == rcfr_pkg::OP_CIRCLE);
            r_cmd.empty      <= w_empty;
            r_cmd.x_lo       <= w_cl_lo_x[6:0];
            r_cmd.x_hi       <= w_cl_hi_x[6:0];
            r_cmd.y_lo       <= w_cl_lo_y[6:0];
            r_cmd.y_hi       <= w_cl_hi_y[6:0];
            r_cmd.start_addr <= '0;
            r_cmd.cx         <= w_cx;
            r_cmd.cy         <= w_cy;
            r_cmd.r2         <= w_r2;
            r_cmd.colour     <= r_colour;
        end
        if (r_state == F_ADDR) begin
            r_cmd.start_addr <= rcfr_pkg::t_addr'(w_yw) + rcfr_pkg::t_addr'(r_cmd.x_lo);
        end
    end

endmodule

[hw/rtl/rcfr_queue.sv]
// ---------------------------------------------------------------------------
// rcfr_queue: short command queue between front and back
// register based fifo; while not full / not empty, one push and one pop per cycle
// ---------------------------------------------------------------------------
module rcfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  rcfr_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output rcfr_pkg::t_cmd o_pop_cmd
);

    rcfr_pkg::t_cmd  r_entry [rcfr_pkg::QDEPTH];
    rcfr_pkg::t_qptr r_wptr;
    rcfr_pkg::t_qptr r_rptr;
    rcfr_pkg::t_qcnt r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != rcfr_pkg::t_qcnt'(rcfr_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_entry[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == rcfr_pkg::t_qptr'(rcfr_pkg::QDEPTH - 1)) ? '0 :
                          rcfr_pkg::t_qptr'(r_wptr + 1'b1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == rcfr_pkg::t_qptr'(rcfr_pkg::QDEPTH - 1)) ? '0 :
                          rcfr_pkg::t_qptr'(r_rptr + 1'b1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= rcfr_pkg::t_qcnt'(r_count + 1'b1);
                2'b01:   r_count <= rcfr_pkg::t_qcnt'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wptr] <= i_push_cmd;
        end
    end

endmodule

[hw/rtl/rcfr_back.sv]
// ---------------------------------------------------------------------------
// rcfr_back: pixel walker, frame store and result register
// clears the frame store after reset, then walks each box one pixel a cycle
// ---------------------------------------------------------------------------
module rcfr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rcfr_pkg::t_pix i_width,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  rcfr_pkg::t_cmd i_pop_cmd,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_is_read_reply,
    output logic [7:0]     o_pixel_red,
    output logic [7:0]     o_pixel_green,
    output logic [7:0]     o_pixel_blue
);

    localparam logic [2:0] B_CLEAR  = 3'd0;
    localparam logic [2:0] B_IDLE   = 3'd1;
    localparam logic [2:0] B_WALK   = 3'd2;
    localparam logic [2:0] B_RD     = 3'd3;
    localparam logic [2:0] B_FINISH = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    rcfr_pkg::t_addr   r_clr;
    rcfr_pkg::t_cmd    r_cmd;
    rcfr_pkg::t_pix    r_x;
    rcfr_pkg::t_pix    r_y;
    rcfr_pkg::t_addr   r_addr;
    rcfr_pkg::t_addr   r_row;
    logic              r_p_valid;
    rcfr_pkg::t_addr   r_p_addr;
    logic [15:0]       r_p_dx2;
    logic [15:0]       r_p_dy2;
    logic              r_out_valid;
    logic              r_out_is_read;
    logic [23:0]       r_out_colour;

    rcfr_pkg::t_coord  w_dx;
    rcfr_pkg::t_coord  w_dy;
    logic signed [19:0] w_dx2;
    logic signed [19:0] w_dy2;
    logic [16:0]       w_d2;
    logic              w_hit;
    logic              w_last_x;
    logic              w_last;
    logic              w_out_free;
    rcfr_pkg::t_addr   w_row_next;
    logic              w_ram_we;
    rcfr_pkg::t_addr   w_ram_waddr;
    logic [23:0]       w_ram_wdata;
    logic              w_ram_re;
    logic [23:0]       w_ram_rdata;

    assign o_pop_ready = (r_state == B_IDLE);
    assign o_clearing  = (r_state == B_CLEAR);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_x    = (r_x == r_cmd.x_hi);
    assign w_last      = w_last_x && (r_y == r_cmd.y_hi);
    assign w_row_next  = r_row + rcfr_pkg::t_addr'(i_width);

    // distance terms of the pixel being issued
    assign w_dx  = rcfr_pkg::t_coord'({3'b000, r_x}) - r_cmd.cx;
    assign w_dy  = rcfr_pkg::t_coord'({3'b000, r_y}) - r_cmd.cy;
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;

    // circle test on the registered squares
    assign w_d2  = {1'b0, r_p_dx2} + {1'b0, r_p_dy2};
    assign w_hit = !r_cmd.is_circle || (w_d2 <= {1'b0, r_cmd.r2});

    assign w_ram_we    = o_clearing || (r_p_valid && w_hit);
    assign w_ram_waddr = o_clearing ? r_clr : r_p_addr;
    assign w_ram_wdata = o_clearing ? '0 : r_cmd.colour;
    assign w_ram_re    = (r_state == B_RD);

    rcfr_ram #(
        .WIDTH (24),
        .DEPTH (rcfr_pkg::DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_cmd.start_addr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: begin
                if (r_clr == rcfr_pkg::t_addr'(rcfr_pkg::DEPTH - 1)) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (i_pop_valid) begin
                    if (i_pop_cmd.empty) n_state = B_FINISH;
                    else if (i_pop_cmd.is_read) n_state = B_RD;
                    else n_state = B_WALK;
                end
            end
            B_WALK: begin
                if (w_last) n_state = B_FINISH;
            end
            B_RD: n_state = B_FINISH;
            B_FINISH: begin
                if (w_out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == B_WALK);
            if (r_state == B_CLEAR) begin
                r_clr <= rcfr_pkg::t_addr'(r_clr + 1'b1);
            end
            if ((r_state == B_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == B_IDLE) && i_pop_valid) begin
            r_cmd  <= i_pop_cmd;
            r_x    <= i_pop_cmd.x_lo;
            r_y    <= i_pop_cmd.y_lo;
            r_addr <= i_pop_cmd.start_addr;
            r_row  <= i_pop_cmd.start_addr;
        end
        if (r_state == B_WALK) begin
            if (w_last_x) begin
                r_x    <= r_cmd.x_lo;
                r_y    <= rcfr_pkg::t_pix'(r_y + 1'b1);
                r_row  <= w_row_next;
                r_addr <= w_row_next;
            end else begin
                r_x    <= rcfr_pkg::t_pix'(r_x + 1'b1);
                r_addr <= rcfr_pkg::t_addr'(r_addr + 1'b1);
            end
        end
        r_p_addr <= r_addr;
        r_p_dx2  <= w_dx2[15:0];
        r_p_dy2  <= w_dy2[15:0];
        if ((r_state == B_FINISH) && w_out_free) begin
            r_out_is_read <= r_cmd.is_read;
            r_out_colour  <= (r_cmd.is_read && !r_cmd.empty) ? w_ram_rdata : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_read_reply = r_out_is_read;
    assign o_pixel_red     = r_out_colour[23:16];
    assign o_pixel_green   = r_out_colour[15:8];
    assign o_pixel_blue    = r_out_colour[7:0];

`ifndef NO_ASSERTIONS
    // no pixel write may overlap the clearing sweep
    a_no_pixel_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_state != B_CLEAR))
        else $error("pixel write during clearing sweep");

    // walker stays inside the clipped box
    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_WALK) |-> (r_x >= r_cmd.x_lo && r_x <= r_cmd.x_hi &&
                                 r_y >= r_cmd.y_lo && r_y <= r_cmd.y_hi))
        else $error("walker left its box");

    // running address tracks row start plus column offset
    a_walk_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_WALK) |->
            (r_addr == r_row + rcfr_pkg::t_addr'(r_x - r_cmd.x_lo)))
        else $error("walker address out of step");

    // a result appears only out of the finish step
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == B_FINISH))
        else $error("result raised outside finish step");
`endif

endmodule

[hw/rtl/rect_circle_fill_raster_top.sv]
// ---------------------------------------------------------------------------
// rect_circle_fill_raster_top: filled rectangle and circle rasterizer
// shape fill engine over a 24-bit rgb frame store with apb configuration
// ---------------------------------------------------------------------------
// usage
//   request channel (i_in_valid / o_in_ready) takes one command: fill
//   rectangle, fill circle or read pixel. every request gives exactly one
//   result on the result channel (o_out_valid / i_out_ready): a draw
//   completion of zeros, or a read reply carrying the stored colour.
//   the apb port sets canvas_width (0x0) and canvas_height (0x4); change
//   them only while no request is in flight.
// flow
//   the front classifies a request (bounding box, then start address) and
//   hands it through a two-entry queue to the back, so the next request is
//   taken while the back still draws. a draw walks the clipped bounding box
//   one pixel per cycle (one frame store write port); an empty or fully
//   clipped draw writes nothing, and a read uses a registered ram read.
// reset
//   after reset the back clears the 4096-word frame store to black, one
//   word a cycle; o_in_ready stays low while it clears, and apb writes
//   are taken throughout.
// back pressure
//   a result waits in the output register; while it is not taken the back
//   holds, the queue fills and then o_in_ready drops.
// ---------------------------------------------------------------------------
module rect_circle_fill_raster_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic signed [8:0] i_center_x,
    input  logic signed [8:0] i_center_y,
    input  logic [7:0]        i_size_a,
    input  logic [7:0]        i_size_b,
    input  logic [7:0]        i_fill_red,
    input  logic [7:0]        i_fill_green,
    input  logic [7:0]        i_fill_blue,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_is_read_reply,
    output logic [7:0]        o_pixel_red,
    output logic [7:0]        o_pixel_green,
    output logic [7:0]        o_pixel_blue
);

    // configuration registers, as written
    rcfr_pkg::t_pix r_canvas_width;
    rcfr_pkg::t_pix r_canvas_height;

    // active canvas, clamped to the frame store size
    rcfr_pkg::t_pix w_width;
    rcfr_pkg::t_pix w_height;

    logic           w_cfg_write;
    logic           w_clearing;
    logic           w_push_valid;
    logic           w_push_ready;
    rcfr_pkg::t_cmd w_push_cmd;
    logic           w_pop_valid;
    logic           w_pop_ready;
    rcfr_pkg::t_cmd w_pop_cmd;

    // apb: zero wait states, write lands in the access phase
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= 7'd64;
            r_canvas_height <= 7'd64;
        end else if (w_cfg_write) begin
            case (paddr[2])
                rcfr_pkg::REG_WIDTH:  r_canvas_width  <= pwdata[6:0];
                rcfr_pkg::REG_HEIGHT: r_canvas_height <= pwdata[6:0];
                default:              r_canvas_width  <= r_canvas_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rcfr_pkg::REG_WIDTH:  prdata = {25'd0, r_canvas_width};
            rcfr_pkg::REG_HEIGHT: prdata = {25'd0, r_canvas_height};
            default:              prdata = '0;
        endcase
    end

    // oversized canvas acts as the full frame store
    assign w_width  = (int'(r_canvas_width) > rcfr_pkg::MAX_WIDTH) ?
                      rcfr_pkg::t_pix'(rcfr_pkg::MAX_WIDTH) : r_canvas_width;
    assign w_height = (int'(r_canvas_height) > rcfr_pkg::MAX_HEIGHT) ?
                      rcfr_pkg::t_pix'(rcfr_pkg::MAX_HEIGHT) : r_canvas_height;

    // front: takes requests, clips the box, computes the start address
    rcfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_block      (w_clearing),
        .i_opcode     (i_opcode),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_size_a     (i_size_a),
        .i_size_b     (i_size_b),
        .i_fill_red   (i_fill_red),
        .i_fill_green (i_fill_green),
        .i_fill_blue  (i_fill_blue),
        .i_width      (w_width),
        .i_height     (w_height),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    // queue decouples classification from the pixel walk
    rcfr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    // back: clearing sweep, pixel walk, frame store, result register
    rcfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_width         (w_width),
        .i_pop_valid     (w_pop_valid),
        .o_pop_ready     (w_pop_ready),
        .i_pop_cmd       (w_pop_cmd),
        .o_clearing      (w_clearing),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_read_reply (o_is_read_reply),
        .o_pixel_red     (o_pixel_red),
        .o_pixel_green   (o_pixel_green),
        .o_pixel_blue    (o_pixel_blue)
    );

endmodule

[bench/tb_rect_circle_fill_raster_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rect_circle_fill_raster_top: self-checking bench for the shape fill engine
// drives rectangle, circle, read and unused-opcode requests with random gaps
// and result stalls, keeps a mirror of the frame store and the canvas size,
// and checks every reply in order over a series of canvas sizes set by apb
// ---------------------------------------------------------------------------

import rcfr_pkg::*;

// one request as it crosses the request channel
typedef struct {
    logic [1:0]        opcode;
    logic signed [8:0] center_x;
    logic signed [8:0] center_y;
    logic [7:0]        size_a;
    logic [7:0]        size_b;
    logic [23:0]       colour;
} cmd_t;

// one reply as it crosses the result channel
typedef struct packed {
    logic        is_read;
    logic [23:0] colour;
} reply_t;

// frame store mirror: paints accepted requests and queues the expected replies
class frame_mirror;
    logic [23:0] pixel_mem [DEPTH];
    int          canvas_w;
    int          canvas_h;
    reply_t      expected_replies [$];
    int          mismatch_count;
    int          replies_checked;
    int          draw_count;
    int          read_count;

    function new();
        foreach (pixel_mem[i]) pixel_mem[i] = '0;
        canvas_w        = MAX_WIDTH;
        canvas_h        = MAX_HEIGHT;
        mismatch_count  = 0;
        replies_checked = 0;
        draw_count      = 0;
        read_count      = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
        if (idx == REG_WIDTH) begin
            canvas_w = value[6:0];
        end else begin
            canvas_h = value[6:0];
        end
    endfunction

    function void apply_request(cmd_t cmd);
        int     w, h, cx, cy, sa, sb;
        int     x_lo, x_hi, y_lo, y_hi, x, y, dx, dy;
        reply_t rep;
        w   = (canvas_w > MAX_WIDTH)  ? MAX_WIDTH  : canvas_w;
        h   = (canvas_h > MAX_HEIGHT) ? MAX_HEIGHT : canvas_h;
        cx  = $signed(cmd.center_x);
        cy  = $signed(cmd.center_y);
        sa  = cmd.size_a;
        sb  = cmd.size_b;
        rep = '0;
        if (cmd.opcode == OP_RECT || cmd.opcode == OP_CIRCLE) begin
            draw_count++;
            // bounding box, then clip to the active canvas
            if (cmd.opcode == OP_RECT) begin
                x_lo = cx - sa / 2;
                x_hi = cx + sa / 2;
                y_lo = cy - sb / 2;
                y_hi = cy + sb / 2;
            end else begin
                x_lo = cx - sa;
                x_hi = cx + sa;
                y_lo = cy - sa;
                y_hi = cy + sa;
            end
            if (x_lo < 0) x_lo = 0;
            if (y_lo < 0) y_lo = 0;
            if (x_hi > w - 1) x_hi = w - 1;
            if (y_hi > h - 1) y_hi = h - 1;
            for (y = y_lo; y <= y_hi; y++) begin
                for (x = x_lo; x <= x_hi; x++) begin
                    dx = x - cx;
                    dy = y - cy;
                    if (cmd.opcode == OP_RECT || dx * dx + dy * dy <= sa * sa) begin
                        pixel_mem[y * w + x] = cmd.colour;
                    end
                end
            end
        end else if (cmd.opcode == OP_READ) begin
            read_count++;
            rep.is_read = 1'b1;
            if (cx >= 0 && cx < w && cy >= 0 && cy < h) begin
                rep.colour = pixel_mem[cy * w + cx];
            end
        end
        expected_replies.push_back(rep);
    endfunction

    function void check_reply(reply_t got);
        reply_t want;
        replies_checked++;
        if (expected_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected reply: read %0b rgb %06h", got.is_read, got.colour);
            end
            return;
        end
        want = expected_replies.pop_front();
        if (got.is_read !== want.is_read || got.colour[23:16] !== want.colour[23:16] ||
            got.colour[15:8] !== want.colour[15:8] || got.colour[7:0] !== want.colour[7:0]) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("reply %0d mismatch: expected read %0b rgb %02h %02h %02h",
                         replies_checked, want.is_read, want.colour[23:16],
                         want.colour[15:8], want.colour[7:0]);
                $display("    got read %0b rgb %02h %02h %02h", got.is_read,
                         got.colour[23:16], got.colour[15:8], got.colour[7:0]);
            end
        end
    endfunction
endclass

module tb_rect_circle_fill_raster_top;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         REQ_IDLE_MAX    = 9;
    localparam int         REPLY_STALL_MAX = 9;
    localparam int         N_PHASES        = 12;
    localparam int         PHASE_ITEMS     = 145;
    // quiet time after the last reply before touching the registers
    localparam int         SETTLE_CYCLES   = 16;
    // reset clear and a full-canvas draw are the longest stretches with no
    // handshake; the limit lies above both, so reaching it means a hang
    localparam int         WATCHDOG_LIMIT  = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_opcode;
    logic signed [8:0] i_center_x;
    logic signed [8:0] i_center_y;
    logic [7:0]        i_size_a;
    logic [7:0]        i_size_b;
    logic [7:0]        i_fill_red;
    logic [7:0]        i_fill_green;
    logic [7:0]        i_fill_blue;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_is_read_reply;
    logic [7:0]        o_pixel_red;
    logic [7:0]        o_pixel_green;
    logic [7:0]        o_pixel_blue;

    frame_mirror mirror;
    int          idle_cycles = 0;
    // per-phase switches that turn off the random gaps on either side
    bit          req_gap_off;
    bit          reply_stall_off;
    // canvas size last written, used to aim the random requests
    int          cur_w;
    int          cur_h;

    rect_circle_fill_raster_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_size_a        (i_size_a),
        .i_size_b        (i_size_b),
        .i_fill_red      (i_fill_red),
        .i_fill_green    (i_fill_green),
        .i_fill_blue     (i_fill_blue),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_read_reply (o_is_read_reply),
        .o_pixel_red     (o_pixel_red),
        .o_pixel_green   (o_pixel_green),
        .o_pixel_blue    (o_pixel_blue)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, inputs were
    // driven at the falling edge so there is no race with the block
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        cmd_t   req;
        reply_t got;
        logic   moved;
        moved = 1'b0;
        // register write lands at the access cycle
        if (psel && penable && pwrite && pready) begin
            mirror.write_reg(paddr[2], pwdata);
            moved = 1'b1;
        end
        // accepted request: paint the mirror and queue its reply
        if (i_rst_n && i_in_valid && o_in_ready) begin
            req.opcode   = i_opcode;
            req.center_x = i_center_x;
            req.center_y = i_center_y;
            req.size_a   = i_size_a;
            req.size_b   = i_size_b;
            req.colour   = {i_fill_red, i_fill_green, i_fill_blue};
            mirror.apply_request(req);
            moved = 1'b1;
        end
        // accepted reply: compare against the oldest expectation
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.is_read = o_is_read_reply;
            got.colour  = {o_pixel_red, o_pixel_green, o_pixel_blue};
            mirror.check_reply(got);
            moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // result side: ready drops for a random stall, possibly none, before
    // each reply, unless the current phase runs without stalls
    // ---------------------------------------------------------------------
    initial begin : reply_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = reply_stall_off ? 0 : $urandom_range(0, REPLY_STALL_MAX);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------

    // called at a falling edge; valid stays high with the payload held
    // until the request is taken, and is only lowered when a gap follows
    task automatic send_request(input cmd_t cmd);
        int gap;
        gap = req_gap_off ? 0 : $urandom_range(0, REQ_IDLE_MAX);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= cmd.opcode;
        i_center_x   <= cmd.center_x;
        i_center_y   <= cmd.center_y;
        i_size_a     <= cmd.size_a;
        i_size_b     <= cmd.size_b;
        i_fill_red   <= cmd.colour[23:16];
        i_fill_green <= cmd.colour[15:8];
        i_fill_blue  <= cmd.colour[7:0];
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // drop valid, wait for every queued reply, then let the back go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (mirror.expected_replies.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write: setup then access, random junk above the 7 register bits
    task automatic write_canvas(input logic idx, input int value);
        logic [31:0] word;
        word      = $urandom;
        word[6:0] = value[6:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic cmd_t make_request(input logic [1:0] op, input int cx, input int cy,
                                          input int sa, input int sb,
                                          input logic [23:0] colour);
        cmd_t cmd;
        cmd.opcode   = op;
        cmd.center_x = cx;
        cmd.center_y = cy;
        cmd.size_a   = sa;
        cmd.size_b   = sb;
        cmd.colour   = colour;
        return cmd;
    endfunction

    // random request aimed at the current canvas: mostly small shapes near
    // the canvas and reads on it or one step past an edge, now and then a huge
    // shape or a request with centre and sizes drawn from their full range
    function automatic cmd_t random_request();
        cmd_t cmd;
        int   tw, th, pick, v;
        tw = (cur_w > MAX_WIDTH)  ? MAX_WIDTH  : cur_w;
        th = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
        if (tw == 0) tw = 1;
        if (th == 0) th = 1;
        pick = $urandom_range(0, 99);
        cmd.opcode = (pick < 35) ? OP_RECT : (pick < 60) ? OP_CIRCLE :
                     (pick < 95) ? OP_READ : OP_UNUSED;
        cmd.colour = $urandom;
        cmd.size_b = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            cmd.center_x = $urandom;
            cmd.center_y = $urandom;
            cmd.size_a   = $urandom;
        end else if (cmd.opcode == OP_READ) begin
            // inside, or one step past an edge
            v = $urandom_range(0, tw + 1);
            cmd.center_x = v - 1;
            v = $urandom_range(0, th + 1);
            cmd.center_y = v - 1;
            cmd.size_a   = $urandom;
        end else begin
            v = $urandom_range(0, tw + 15);
            cmd.center_x = v - 8;
            v = $urandom_range(0, th + 15);
            cmd.center_y = v - 8;
            if ($urandom_range(0, 29) == 0) begin
                cmd.size_a = $urandom;
            end else if (cmd.opcode == OP_CIRCLE) begin
                cmd.size_a = $urandom_range(0, 10);
            end else begin
                cmd.size_a = $urandom_range(0, 16);
                cmd.size_b = $urandom_range(0, 16);
            end
        end
        return cmd;
    endfunction

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        int p;
        mirror          = new();
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_opcode        = OP_RECT;
        i_center_x      = '0;
        i_center_y      = '0;
        i_size_a        = '0;
        i_size_b        = '0;
        i_fill_red      = '0;
        i_fill_green    = '0;
        i_fill_blue     = '0;
        i_out_ready     = 1'b0;
        req_gap_off     = 1'b0;
        reply_stall_off = 1'b0;
        cur_w           = MAX_WIDTH;
        cur_h           = MAX_HEIGHT;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset canvas of 64 x 64
        // frame store is black after reset
        send_request(make_request(OP_READ, 0, 0, 0, 0, 24'h0));
        // small rectangle, halves rounded down, then its corners and a miss
        send_request(make_request(OP_RECT, 10, 10, 4, 6, 24'hff0000));
        send_request(make_request(OP_READ, 8, 7, 0, 0, 24'h0));
        send_request(make_request(OP_READ, 12, 13, 0, 0, 24'h0));
        send_request(make_request(OP_READ, 13, 13, 0, 0, 24'h0));
        // zero size is a single pixel, here the far corner
        send_request(make_request(OP_RECT, 63, 63, 0, 0, 24'hffffff));
        send_request(make_request(OP_READ, 63, 63, 0, 0, 24'h0));
        // huge rectangles entirely off the canvas
        send_request(make_request(OP_RECT, -256, -256, 255, 255, 24'h123456));
        send_request(make_request(OP_RECT, 255, 255, 255, 255, 24'habcdef));
        // radius zero circle
        send_request(make_request(OP_CIRCLE, 32, 32, 0, 255, 24'h00ff00));
        send_request(make_request(OP_READ, 32, 32, 0, 0, 24'h0));
        // circle hanging over the left edge, a read inside, one on its rim, one just past
        send_request(make_request(OP_CIRCLE, -3, 10, 6, 0, 24'h0000ff));
        send_request(make_request(OP_READ, 0, 10, 0, 0, 24'h0));
        send_request(make_request(OP_READ, 3, 10, 0, 0, 24'h0));
        send_request(make_request(OP_READ, 4, 10, 0, 0, 24'h0));
        // biggest radius, centered far enough out to miss every pixel
        send_request(make_request(OP_CIRCLE, 255, 255, 255, 255, 24'h777777));
        send_request(make_request(OP_CIRCLE, -256, 255, 255, 0, 24'h888888));
        // unused opcode paints nothing and answers as a draw
        send_request(make_request(OP_UNUSED, -1, 5, 255, 255, 24'hffffff));
        // reads outside the canvas answer black
        send_request(make_request(OP_READ, -1, 0, 0, 0, 24'h0));
        send_request(make_request(OP_READ, 64, 0, 0, 0, 24'h0));
        send_request(make_request(OP_READ, 0, 64, 0, 0, 24'h0));
        send_request(make_request(OP_READ, -256, -256, 255, 255, 24'h0));
        send_request(make_request(OP_READ, 255, 255, 0, 0, 24'h0));
        // rectangle covering the whole canvas, then a read inside it
        send_request(make_request(OP_RECT, 0, 0, 255, 128, 24'h5a00a5));
        send_request(make_request(OP_READ, 40, 50, 0, 0, 24'h0));
        settle();

        // random phases; the frame store is kept across canvas changes,
        // so every resize also checks the new address mapping
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin cur_w = 1;   cur_h = 1;   end
                1: begin cur_w = 0;   cur_h = 17;  end  // zero width clips all
                2: begin cur_w = 64;  cur_h = 1;   end
                3: begin cur_w = 1;   cur_h = 64;  end
                4: begin cur_w = 127; cur_h = 127; end  // oversized, acts as 64
                5: begin cur_w = 23;  cur_h = 0;   end  // zero height clips all
                6: begin cur_w = 65;  cur_h = 64;  end
                7: begin cur_w = 64;  cur_h = 64;  end
                default: begin
                    cur_w = $urandom_range(1, MAX_WIDTH);
                    cur_h = $urandom_range(1, MAX_HEIGHT);
                end
            endcase
            write_canvas(REG_WIDTH, cur_w);
            write_canvas(REG_HEIGHT, cur_h);
            req_gap_off     = ($urandom_range(0, 3) == 0);
            reply_stall_off = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_request(random_request());
            settle();
        end

        $display("checked %0d replies: %0d draws and %0d reads", mirror.replies_checked,
                 mirror.draw_count, mirror.read_count);
        $display("%0d canvas sizes, among them empty, single-pixel and oversized ones",
                 N_PHASES + 1);
        if (mirror.mismatch_count == 0 && mirror.expected_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d replies missing", mirror.mismatch_count,
                     mirror.expected_replies.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
